[hdl/lsfs_pkg.sv]
`default_nettype none
package lsfs_pkg;

    // op codes of the command word
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_SHOW  = 2'd1;
    localparam logic [1:0] OP_BLANK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_BRIGHTNESS  = 2'd1;
    localparam logic [1:0] CFG_DIVIDER     = 2'd2;

    localparam logic [7:0] HDR_MARK       = 8'hE0;
    localparam logic [7:0] END_MARK       = 8'hFF;
    localparam int         END_BASE       = 6;
    localparam int         END_STEP_SHIFT = 4;

    localparam logic [2:0] BYTES_FULL = 3'd4;

    typedef struct packed {
        logic [5:0] pixel_count;
        logic [4:0] global_brightness;
        logic [7:0] color_divider;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACK,
        S_START,
        S_RD,
        S_LOAD,
        S_DIVSTART,
        S_DIVWAIT,
        S_PIX,
        S_END
    } t_state;

endpackage
`default_nettype wire

[hdl/lsfs_cmd_if.sv]
`default_nettype none
interface lsfs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [4:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, op, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, op, pixel_index, red, green, blue, output ready);
endinterface
`default_nettype wire

[hdl/lsfs_word_if.sv]
`default_nettype none
interface lsfs_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, out_word, byte_count, last, input ready);
    modport sink   (input valid, out_word, byte_count, last, output ready);
endinterface
`default_nettype wire

[hdl/lsfs_pixel_mem.sv]
`default_nettype none
module lsfs_pixel_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [23:0]       i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [23:0]       o_rdata
);

    logic [23:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [23:0]      r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // entries never written read as black
    always_ff @(posedge i_clk) begin
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hdl/lsfs_div.sv]
`default_nettype none
module lsfs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsfs_pkg::t_div_req i_req,
    output lsfs_pkg::t_div_rsp      o_rsp
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_rem;
    logic [7:0] r_quo;
    logic [7:0] r_dvs;
    logic [8:0] trial;
    logic [8:0] shifted;
    logic       q_bit;
    logic [7:0] n_rem;

    // one restoring step per cycle, MSB first
    always_comb begin
        shifted = {r_rem, r_quo[7]};
        trial   = shifted - {1'b0, r_dvs};
        q_bit   = !trial[8];
        n_rem   = q_bit ? trial[7:0] : shifted[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[6:0], q_bit};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(r_busy) |-> r_cnt == 3'd0)
        else $error("divider run did not start at step zero");

endmodule
`default_nettype wire

[hdl/lsfs_ctrl.sv]
`default_nettype none
module lsfs_ctrl #(
    parameter int MAX_PIXELS = 32,
    parameter int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lsfs_pkg::t_cfg      i_cfg,
    lsfs_cmd_if.sink                 i_cmd,
    lsfs_word_if.source              o_word,
    output logic                     o_mem_we,
    output logic [ADDR_W-1:0]        o_mem_waddr,
    output logic [23:0]              o_mem_wdata,
    output logic [ADDR_W-1:0]        o_mem_raddr,
    input  wire logic [23:0]         i_mem_rdata,
    output lsfs_pkg::t_div_req       o_div_req,
    input  wire lsfs_pkg::t_div_rsp  i_div_rsp
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int LEFT_W = $clog2(lsfs_pkg::END_BASE +
                                   MAX_PIXELS / (2 ** lsfs_pkg::END_STEP_SHIFT) + 1);

    lsfs_pkg::t_state r_state, n_state;

    logic              r_ov;
    logic [31:0]       r_word;
    logic [2:0]        r_bc;
    logic              r_last;

    logic              r_blank;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_pix;
    logic [LEFT_W-1:0] r_left;
    logic              r_first;
    logic [7:0]        r_hdr;
    logic [7:0]        r_dvs;
    logic [23:0]       r_px;
    logic [23:0]       r_acc;
    logic [1:0]        r_ch;

    logic              slot_free;
    logic              emit;
    logic              cmd_ready;
    logic              div_start;
    logic [31:0]       n_word;
    logic [2:0]        n_bc;
    logic              n_last;
    logic [2:0]        take;
    logic              cmd_acc;
    logic              is_frame;
    logic              last_pix;
    logic [CNT_W-1:0]  clamp_cnt;
    logic [7:0]        chan;

    assign slot_free = !r_ov || o_word.ready;
    assign cmd_acc   = i_cmd.valid && cmd_ready;
    assign is_frame  = (i_cmd.op == lsfs_pkg::OP_SHOW) || (i_cmd.op == lsfs_pkg::OP_BLANK);
    assign last_pix  = (r_pix == r_cnt - CNT_W'(1));
    assign take      = (r_left > LEFT_W'(4)) ? 3'd4 : r_left[2:0];
    assign clamp_cnt = (i_cfg.pixel_count > 6'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                             : CNT_W'(i_cfg.pixel_count);

    always_comb begin
        case (r_ch)
            2'd0:    chan = r_px[7:0];
            2'd1:    chan = r_px[15:8];
            default: chan = r_px[23:16];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsfs_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = is_frame ? lsfs_pkg::S_START : lsfs_pkg::S_ACK;
                end
            end
            lsfs_pkg::S_ACK: begin
                if (slot_free) n_state = lsfs_pkg::S_IDLE;
            end
            lsfs_pkg::S_START: begin
                if (slot_free) begin
                    n_state = (r_cnt == '0) ? lsfs_pkg::S_END : lsfs_pkg::S_RD;
                end
            end
            lsfs_pkg::S_RD:       n_state = lsfs_pkg::S_LOAD;
            lsfs_pkg::S_LOAD:     n_state = lsfs_pkg::S_DIVSTART;
            lsfs_pkg::S_DIVSTART: n_state = lsfs_pkg::S_DIVWAIT;
            lsfs_pkg::S_DIVWAIT: begin
                if (i_div_rsp.done) begin
                    n_state = (r_ch == 2'd2) ? lsfs_pkg::S_PIX : lsfs_pkg::S_DIVSTART;
                end
            end
            lsfs_pkg::S_PIX: begin
                if (slot_free) begin
                    n_state = last_pix ? lsfs_pkg::S_END : lsfs_pkg::S_RD;
                end
            end
            lsfs_pkg::S_END: begin
                if (slot_free && r_left <= LEFT_W'(4)) n_state = lsfs_pkg::S_IDLE;
            end
            default: n_state = lsfs_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        cmd_ready = 1'b0;
        emit      = 1'b0;
        div_start = 1'b0;
        n_word    = '0;
        n_bc      = '0;
        n_last    = 1'b0;
        unique case (r_state)
            lsfs_pkg::S_IDLE:     cmd_ready = 1'b1;
            lsfs_pkg::S_ACK: begin
                emit   = slot_free;
                n_last = 1'b1;
            end
            lsfs_pkg::S_START: begin
                emit = slot_free;
                n_bc = lsfs_pkg::BYTES_FULL;
            end
            lsfs_pkg::S_DIVSTART: div_start = 1'b1;
            lsfs_pkg::S_PIX: begin
                emit   = slot_free;
                n_word = {r_hdr, r_acc};
                n_bc   = lsfs_pkg::BYTES_FULL;
            end
            lsfs_pkg::S_END: begin
                emit   = slot_free;
                n_word = r_first ? {lsfs_pkg::END_MARK, 24'h0} : '0;
                n_bc   = take;
                n_last = (r_left <= LEFT_W'(4));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsfs_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_word.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word <= n_word;
            r_bc   <= n_bc;
            r_last <= n_last;
        end
        if (cmd_acc) begin
            r_blank <= (i_cmd.op == lsfs_pkg::OP_BLANK);
            r_cnt   <= clamp_cnt;
            r_pix   <= '0;
            r_left  <= LEFT_W'(lsfs_pkg::END_BASE) +
                       LEFT_W'(clamp_cnt >> lsfs_pkg::END_STEP_SHIFT);
            r_first <= 1'b1;
            r_hdr   <= lsfs_pkg::HDR_MARK | {3'b000, i_cfg.global_brightness};
            r_dvs   <= (i_cfg.color_divider == '0) ? 8'd1 : i_cfg.color_divider;
        end
        if (r_state == lsfs_pkg::S_LOAD) begin
            r_px <= r_blank ? '0 : i_mem_rdata;
            r_ch <= '0;
        end
        if (r_state == lsfs_pkg::S_DIVWAIT && i_div_rsp.done) begin
            // shift in blue, then green, then red
            r_acc <= {r_acc[15:0], i_div_rsp.quotient};
            r_ch  <= r_ch + 2'd1;
        end
        if (r_state == lsfs_pkg::S_PIX && slot_free) begin
            r_pix <= r_pix + CNT_W'(1);
        end
        if (r_state == lsfs_pkg::S_END && slot_free) begin
            r_left  <= r_left - LEFT_W'(take);
            r_first <= 1'b0;
        end
    end

    assign i_cmd.ready       = cmd_ready;
    assign o_word.valid      = r_ov;
    assign o_word.out_word   = r_word;
    assign o_word.byte_count = r_bc;
    assign o_word.last       = r_last;

    assign o_mem_we    = cmd_acc && (i_cmd.op == lsfs_pkg::OP_SET) &&
                         ({1'b0, i_cmd.pixel_index} < 6'(MAX_PIXELS));
    assign o_mem_waddr = ADDR_W'(i_cmd.pixel_index);
    assign o_mem_wdata = {i_cmd.red, i_cmd.green, i_cmd.blue};
    assign o_mem_raddr = r_pix[ADDR_W-1:0];

    assign o_div_req.start    = div_start;
    assign o_div_req.dividend = chan;
    assign o_div_req.divisor  = r_dvs;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> r_state == lsfs_pkg::S_DIVWAIT)
        else $error("quotient arrived outside the divide wait");

    a_pix_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsfs_pkg::S_RD || r_state == lsfs_pkg::S_PIX) |-> r_pix < r_cnt)
        else $error("pixel pointer ran past the frame length");

    a_end_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsfs_pkg::S_END |-> r_left != '0)
        else $error("end frame state with no bytes left");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && n_last |=> r_state == lsfs_pkg::S_IDLE)
        else $error("final word sent but sequencer did not return to idle");

endmodule
`default_nettype wire

[hdl/led_strip_frame_serializer.sv]
`default_nettype none
// LED strip frame encoder for APA102-style strips. Commands arrive on i_cmd:
// set pixel writes one RGB entry of the pixel store (cleared to black at reset)
// and answers with one empty word marked last; show sends a start word of four
// zero bytes, one word {0xE0|brightness, blue, green, red} per pixel with each
// channel divided by color_divider, then an end frame of 6 + count/16 bytes
// (0xFF first, rest zero) packed into words with a byte count; blank sends the
// same frame with black pixels. Every word puts its first byte in bits 31:24.
// One command is handled at a time and i_cmd.ready is low until its last word
// is loaded into the output register. Each pixel passes through a read and a
// load step, its three color channels through the one bit-serial divider (a
// start, 8 restoring steps and a collect for each channel), and a send step.
// Write configuration only while no command is in progress; a frame uses the
// settings captured when its command is accepted.
module led_strip_frame_serializer #(
    parameter int MAX_PIXELS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lsfs_cmd_if.sink         i_cmd,
    lsfs_word_if.source      o_word,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    lsfs_pkg::t_cfg     r_cfg;
    lsfs_pkg::t_div_req div_req;
    lsfs_pkg::t_div_rsp div_rsp;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [23:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [23:0]       mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_count       <= 6'd32;
            r_cfg.global_brightness <= 5'd31;
            r_cfg.color_divider     <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsfs_pkg::CFG_PIXEL_COUNT: r_cfg.pixel_count       <= i_cfg_data[5:0];
                lsfs_pkg::CFG_BRIGHTNESS:  r_cfg.global_brightness <= i_cfg_data[4:0];
                lsfs_pkg::CFG_DIVIDER:     r_cfg.color_divider     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsfs_pixel_mem #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lsfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lsfs_ctrl #(
        .MAX_PIXELS (MAX_PIXELS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (i_cmd),
        .o_word      (o_word),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

endmodule
`default_nettype wire
